// ===== hdl/ohlcv_time_bar_resampler_core_assert.svh =====
// Assertion macros shared by the resampler RTL files.
`ifndef OHLCV_TIME_BAR_RESAMPLER_CORE_ASSERT_SVH
`define OHLCV_TIME_BAR_RESAMPLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define OTBR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define OTBR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/otbr_pkg.sv =====
// Types and constants of the OHLCV time-bar resampler.
`default_nettype none
package otbr_pkg;

	localparam int TIME_BITS  = 48;
	localparam int PRICE_BITS = 32;
	localparam int BVOL_BITS  = 32;
	localparam int VOL_BITS   = 40;
	localparam int MS_BITS    = 23;
	localparam int CNT_BITS   = $clog2(TIME_BITS);

	localparam logic [MS_BITS-1:0] MS_RESET = MS_BITS'(60000);

	typedef enum logic {
		REQ_BAR   = 1'b0,
		REQ_FLUSH = 1'b1
	} req_kind_t;

	typedef enum logic {
		KIND_DONE = 1'b0,
		KIND_RUN  = 1'b1
	} out_kind_t;

	typedef struct packed {
		req_kind_t             req_type;
		logic [TIME_BITS-1:0]  bar_time;
		logic [PRICE_BITS-1:0] bar_open;
		logic [PRICE_BITS-1:0] bar_high;
		logic [PRICE_BITS-1:0] bar_low;
		logic [PRICE_BITS-1:0] bar_close;
		logic [BVOL_BITS-1:0]  bar_volume;
	} req_t;

	typedef struct packed {
		out_kind_t             out_kind;
		logic [TIME_BITS-1:0]  out_start;
		logic [PRICE_BITS-1:0] out_open;
		logic [PRICE_BITS-1:0] out_high;
		logic [PRICE_BITS-1:0] out_low;
		logic [PRICE_BITS-1:0] out_close;
		logic [VOL_BITS-1:0]   out_volume;
		logic                  out_last;
	} res_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_EMIT_RUN
	} state_t;

	typedef struct packed {
		logic div_start;
		logic load_done;
		logic done_last;
		logic load_run;
		logic merge_upd;
		logic open_new;
		logic clr_valid;
	} ctl_t;

endpackage
`default_nettype wire

// ===== hdl/ohlcv_time_bar_resampler_core.sv =====
// Top level of the OHLCV time-bar resampler: sequencer, bucket state, output register.
// Folds one-minute bars into bars of bucket_ms milliseconds. One request at a time:
// in_stall is high from acceptance until the request's results are loaded into the
// output register. A bar that merges into the open bucket is accepted, evaluated and
// emitted as an update. A bar that opens a new bucket is accepted, evaluated, divided
// and emitted; its start is the bar time minus (time mod period), and that remainder
// comes from a restoring unit that retires one of the 48 time bits per cycle. A flush
// is accepted and evaluated. Extra cycles are added while out_stall holds the output
// register. A new request may be accepted while a result waits in the output register.
// The user must write bucket_ms through cfg_wr_en/cfg_wr_data only while idle; the
// block does not enforce it. Period zero acts as one ms. Volume saturates at 2^40-1.
`default_nettype none
module ohlcv_time_bar_resampler_core (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_wr_en,
	input  wire [otbr_pkg::MS_BITS-1:0] cfg_wr_data,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire otbr_pkg::req_t         in_req,
	output logic                        out_valid,
	input  wire                         out_stall,
	output otbr_pkg::res_t              out_res
);
	import otbr_pkg::*;

	`include "ohlcv_time_bar_resampler_core_assert.svh"

	state_t state_q, state_nxt;
	ctl_t   ctl;

	// configuration
	logic [MS_BITS-1:0] bucket_ms_q;
	logic [MS_BITS-1:0] period;

	// latched request
	req_t req_q;

	// open bucket
	logic                  bkt_valid_q;
	logic [TIME_BITS-1:0]  bkt_start_q;
	logic [PRICE_BITS-1:0] run_open_q;
	logic [PRICE_BITS-1:0] run_high_q;
	logic [PRICE_BITS-1:0] run_low_q;
	logic [PRICE_BITS-1:0] run_close_q;
	logic [VOL_BITS-1:0]   run_vol_q;

	// output register
	logic out_valid_q;
	res_t out_q;
	res_t res;

	logic accept;
	logic out_free;
	logic merge;
	logic [TIME_BITS:0] diff;
	logic [VOL_BITS:0]  vol_sum;

	div_stat_t          div_stat;
	logic [MS_BITS-1:0] div_rem;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign period   = (bucket_ms_q == '0) ? MS_BITS'(1) : bucket_ms_q;

	// merge test: late bar, or inside the period after the bucket start
	always_comb begin
		diff  = {1'b0, req_q.bar_time} - {1'b0, bkt_start_q};
		merge = bkt_valid_q && (diff[TIME_BITS] ||
			(diff[TIME_BITS-1:0] < TIME_BITS'(period)));
	end

	assign vol_sum = {1'b0, run_vol_q} + (VOL_BITS + 1)'(req_q.bar_volume);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_ms_q <= MS_RESET;
		end else if (cfg_wr_en) begin
			bucket_ms_q <= cfg_wr_data;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = ST_EVAL;
			end
			ST_EVAL: begin
				if (req_q.req_type == REQ_FLUSH) begin
					if (!bkt_valid_q || out_free) state_nxt = ST_IDLE;
				end else if (merge) begin
					state_nxt = ST_EMIT_RUN;
				end else if (!bkt_valid_q || out_free) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) state_nxt = ST_EMIT_RUN;
			end
			ST_EMIT_RUN: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_IDLE: ;
			ST_EVAL: begin
				if (req_q.req_type == REQ_FLUSH) begin
					if (bkt_valid_q && out_free) begin
						ctl.load_done = 1'b1;
						ctl.done_last = 1'b1;
						ctl.clr_valid = 1'b1;
					end
				end else if (merge) begin
					ctl.merge_upd = 1'b1;
				end else if (!bkt_valid_q) begin
					ctl.div_start = 1'b1;
				end else if (out_free) begin
					// close the old bucket before opening the new one
					ctl.load_done = 1'b1;
					ctl.div_start = 1'b1;
				end
			end
			ST_DIV: begin
				ctl.open_new = div_stat.done;
			end
			ST_EMIT_RUN: begin
				ctl.load_run = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bkt_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.clr_valid) begin
				bkt_valid_q <= 1'b0;
			end else if (ctl.open_new) begin
				bkt_valid_q <= 1'b1;
			end
			if (ctl.load_done || ctl.load_run) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_req;
		end
	end

	// bucket contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bkt_start_q <= '0;
			run_open_q  <= '0;
			run_high_q  <= '0;
			run_low_q   <= '0;
			run_close_q <= '0;
			run_vol_q   <= '0;
		end else if (ctl.open_new) begin
			bkt_start_q <= req_q.bar_time - TIME_BITS'(div_rem);
			run_open_q  <= req_q.bar_open;
			run_high_q  <= req_q.bar_high;
			run_low_q   <= req_q.bar_low;
			run_close_q <= req_q.bar_close;
			run_vol_q   <= VOL_BITS'(req_q.bar_volume);
		end else if (ctl.merge_upd) begin
			if (req_q.bar_high > run_high_q) run_high_q <= req_q.bar_high;
			if (req_q.bar_low < run_low_q) run_low_q <= req_q.bar_low;
			run_close_q <= req_q.bar_close;
			run_vol_q   <= vol_sum[VOL_BITS] ? {VOL_BITS{1'b1}} : vol_sum[VOL_BITS-1:0];
		end
	end

	always_comb begin
		res.out_kind   = ctl.load_run ? KIND_RUN : KIND_DONE;
		res.out_start  = bkt_start_q;
		res.out_open   = run_open_q;
		res.out_high   = run_high_q;
		res.out_low    = run_low_q;
		res.out_close  = run_close_q;
		res.out_volume = run_vol_q;
		res.out_last   = ctl.load_run || ctl.done_last;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_done || ctl.load_run) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	otbr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (req_q.bar_time),
		.divisor  (period),
		.stat     (div_stat),
		.rem      (div_rem)
	);

	`OTBR_ASSERT_NXT(a_accept_eval, clk, arst_n, accept, state_q == ST_EVAL,
		"accepted request not evaluated")
	`OTBR_ASSERT_IMP(a_emit_has_bkt, clk, arst_n, state_q == ST_EMIT_RUN, bkt_valid_q,
		"update emitted with no open bucket")
	`OTBR_ASSERT_IMP(a_done_in_div, clk, arst_n, div_stat.done, state_q == ST_DIV,
		"remainder finished outside divide state")

endmodule
`default_nettype wire

// ===== hdl/otbr_div.sv =====
// Bit-serial remainder unit: one restoring step per cycle.
`default_nettype none
module otbr_div (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	input  wire [otbr_pkg::TIME_BITS-1:0] dividend,
	input  wire [otbr_pkg::MS_BITS-1:0]   divisor,
	output otbr_pkg::div_stat_t           stat,
	output logic [otbr_pkg::MS_BITS-1:0]  rem
);
	import otbr_pkg::*;

	`include "ohlcv_time_bar_resampler_core_assert.svh"

	logic [TIME_BITS-1:0] dvd_q;
	logic [MS_BITS-1:0]   dsr_q;
	logic [MS_BITS-1:0]   rem_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [MS_BITS:0]   trial;
	logic               ge;
	logic [MS_BITS-1:0] rem_nxt;

	// shift in next dividend bit, subtract when it fits
	always_comb begin
		trial   = {rem_q, dvd_q[TIME_BITS-1]};
		ge      = (trial >= {1'b0, dsr_q});
		rem_nxt = ge ? MS_BITS'(trial - {1'b0, dsr_q}) : trial[MS_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= MS_BITS'(1);
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(TIME_BITS - 1);
				rem_q  <= '0;
				dsr_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= rem_nxt;
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TIME_BITS-2:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

	`OTBR_ASSERT_IMP(a_rem_below_dsr, clk, arst_n, busy_q, rem_q < dsr_q, "remainder out of range")
	`OTBR_ASSERT_NXT(a_start_busy, clk, arst_n, start, busy_q, "start did not begin")
	`OTBR_ASSERT_NXT(a_busy_holds, clk, arst_n, busy_q && !start && (cnt_q != '0), busy_q,
		"divider quit early")

endmodule
`default_nettype wire
